@@ rtl/oett_pkg.sv @@
// Shared types and constants for the overlap event track table.
package oett_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_BITS = 4;
  localparam int CNT_BITS = 5;
  localparam int COORD_BITS = 12;
  localparam int FRAME_BITS = 24;
  localparam int EDGE_BITS = COORD_BITS + 1;
  localparam int AREA_BITS = 2 * COORD_BITS;
  localparam int OV_BITS = 2 * EDGE_BITS;
  localparam int LHS_BITS = OV_BITS + 4 + AREA_BITS + 1;
  localparam int RHS_BITS = AREA_BITS + 4 + AREA_BITS;
  localparam int IN_TDATA_BITS = 72;
  localparam int OUT_TDATA_BITS = 16;

  localparam logic CFG_FPS = 1'b0;
  localparam logic CFG_MIN_START = 1'b1;

  localparam logic [7:0] FPS_RESET = 8'd25;
  localparam logic [15:0] MIN_START_RESET = 16'd17;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  typedef struct packed {
    box_t                  box;
    logic [FRAME_BITS-1:0] start;
    logic [FRAME_BITS-1:0] end_frame;
    logic                  open;
    logic                  seen;
  } entry_t;

endpackage

@@ rtl/overlap_event_track_table_top.sv @@
// Detection word: each open entry is compared in states calc0, calc1, cmp until one matches; others step past.
// End-of-frame sweep: every table entry is visited once in turn, then the result word is written.
// One word in flight; the table chain shifts one slot per step past one overlap unit.
// The result register frees the input side while a word waits on the output.
// Synchronous reset empties the table and loads fps 25, min start frame 17.
module overlap_event_track_table_top import oett_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // box_x, box_y, box_w, box_h, frame_number
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  // op
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // matched, slot_index, table_full, closed_count, zero pad
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STEP  = 3'd1;
  localparam logic [2:0] ST_CALC0 = 3'd2;
  localparam logic [2:0] ST_CALC1 = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_SWEEP = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]            state;
  logic                  op_r;
  box_t                  det;
  logic [FRAME_BITS-1:0] frame_r;
  logic [CNT_BITS-1:0]   cnt, n_orig, j, closed;
  logic                  found;
  logic [IDX_BITS-1:0]   slot;
  logic [7:0]            fps;
  logic [15:0]           min_start;

  entry_t                q [DEPTH];
  entry_t                head, wr_data;
  logic                  shift, wr_en;
  logic [IDX_BITS-1:0]   wr_idx, last_idx;
  logic                  hit, remove, out_free, full, done;
  logic [FRAME_BITS:0]   keep_limit;

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign head      = q[0];
  assign out_free  = !m_tvalid || m_tready;
  assign full      = (cnt == CNT_BITS'(DEPTH));
  assign done      = (j == n_orig);
  assign last_idx  = IDX_BITS'(cnt - CNT_BITS'(1));

  assign keep_limit = {1'b0, head.start} + (FRAME_BITS + 1)'({fps, 1'b0});
  assign remove = ({1'b0, frame_r} < keep_limit) ||
                  (head.start < FRAME_BITS'(min_start));

  oett_match u_match (
    .clk (clk),
    .a   (head.box),
    .b   (det),
    .hit (hit)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    entry_t nb;
    if (k == DEPTH - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_body
      assign nb = q[k+1];
    end
    oett_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .wr      (wr_en && (wr_idx == IDX_BITS'(k))),
      .wr_data (wr_data),
      .nb      (nb),
      .q       (q[k])
    );
  end

  always_comb begin
    shift   = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = last_idx;
    wr_data = head;
    unique case (state)
      ST_STEP: begin
        if (!done && (found || !head.open)) begin
          shift = 1'b1;
          wr_en = 1'b1;
        end
      end
      ST_CMP: begin
        shift = 1'b1;
        wr_en = 1'b1;
        if (hit) begin
          wr_data.box  = det;
          wr_data.seen = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (!done) begin
          shift = 1'b1;
          if (head.seen) begin
            wr_en        = 1'b1;
            wr_data.seen = 1'b0;
          end else if (!head.open) begin
            wr_en = 1'b1;
          end else if (!remove) begin
            wr_en             = 1'b1;
            wr_data.end_frame = frame_r;
            wr_data.open      = 1'b0;
          end
        end
      end
      ST_FIN: begin
        if (!op_r && !found && !full && out_free) begin
          wr_en             = 1'b1;
          wr_idx            = IDX_BITS'(cnt);
          wr_data.box       = det;
          wr_data.start     = frame_r;
          wr_data.end_frame = '0;
          wr_data.open      = 1'b1;
          wr_data.seen      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fps       <= FPS_RESET;
      min_start <= MIN_START_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FPS:       fps       <= cfg_data[7:0];
        CFG_MIN_START: min_start <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_r    <= s_tuser;
            det.x   <= s_tdata[0 +: COORD_BITS];
            det.y   <= s_tdata[COORD_BITS +: COORD_BITS];
            det.w   <= s_tdata[2*COORD_BITS +: COORD_BITS];
            det.h   <= s_tdata[3*COORD_BITS +: COORD_BITS];
            frame_r <= s_tdata[4*COORD_BITS +: FRAME_BITS];
            j       <= '0;
            n_orig  <= cnt;
            found   <= 1'b0;
            slot    <= '0;
            closed  <= '0;
            state   <= s_tuser ? ST_SWEEP : ST_STEP;
          end
        end
        ST_STEP: begin
          if (done) begin
            state <= ST_FIN;
          end else if (found || !head.open) begin
            j <= j + CNT_BITS'(1);
          end else begin
            state <= ST_CALC0;
          end
        end
        ST_CALC0: state <= ST_CALC1;
        ST_CALC1: state <= ST_CMP;
        ST_CMP: begin
          if (hit) begin
            found <= 1'b1;
            slot  <= IDX_BITS'(j);
          end
          j     <= j + CNT_BITS'(1);
          state <= ST_STEP;
        end
        ST_SWEEP: begin
          if (done) begin
            state <= ST_FIN;
          end else begin
            j <= j + CNT_BITS'(1);
            if (!head.seen) begin
              if (head.open && remove) begin
                cnt <= cnt - CNT_BITS'(1);
              end else begin
                closed <= closed + CNT_BITS'(1);
              end
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
            if (op_r) begin
              m_tdata <= OUT_TDATA_BITS'({closed, 1'b0, {IDX_BITS{1'b0}}, 1'b0});
            end else if (found) begin
              m_tdata <= OUT_TDATA_BITS'({{CNT_BITS{1'b0}}, 1'b0, slot, 1'b1});
            end else if (full) begin
              m_tdata <= OUT_TDATA_BITS'({{CNT_BITS{1'b0}}, 1'b1, {IDX_BITS{1'b0}}, 1'b0});
            end else begin
              m_tdata <= OUT_TDATA_BITS'({{CNT_BITS{1'b0}}, 1'b0, IDX_BITS'(cnt), 1'b0});
              cnt     <= cnt + CNT_BITS'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/oett_cell.sv @@
// One table slot of the shifting entry chain.
module oett_cell import oett_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  logic   wr,
  input  entry_t wr_data,
  input  entry_t nb,
  output entry_t q
);

  always_ff @(posedge clk) begin
    if (wr) begin
      q <= wr_data;
    end else if (shift) begin
      q <= nb;
    end
  end

endmodule

@@ rtl/oett_match.sv @@
// Two-stage box overlap test at the head of the chain.
module oett_match import oett_pkg::*; (
  input  logic clk,
  input  box_t a,
  input  box_t b,
  output logic hit
);

  logic [EDGE_BITS-1:0] ax1, ay1, bx1, by1;
  logic [EDGE_BITS-1:0] lox, hix, loy, hiy, sx, sy;
  logic                 touch_c;

  logic                 touch1, touch2;
  logic [OV_BITS-1:0]   ov;
  logic [AREA_BITS-1:0] a1, a2;
  logic [LHS_BITS-1:0]  lhs;
  logic [RHS_BITS-1:0]  rhs;

  always_comb begin
    ax1 = EDGE_BITS'(a.x) + EDGE_BITS'(a.w);
    ay1 = EDGE_BITS'(a.y) + EDGE_BITS'(a.h);
    bx1 = EDGE_BITS'(b.x) + EDGE_BITS'(b.w);
    by1 = EDGE_BITS'(b.y) + EDGE_BITS'(b.h);
    touch_c = !(ax1 < EDGE_BITS'(b.x) || EDGE_BITS'(a.x) > bx1 ||
                ay1 < EDGE_BITS'(b.y) || EDGE_BITS'(a.y) > by1);
    lox = (a.x > b.x) ? EDGE_BITS'(a.x) : EDGE_BITS'(b.x);
    hix = (ax1 < bx1) ? ax1 : bx1;
    loy = (a.y > b.y) ? EDGE_BITS'(a.y) : EDGE_BITS'(b.y);
    hiy = (ay1 < by1) ? ay1 : by1;
    sx = (hix >= lox) ? hix - lox : '0;
    sy = (hiy >= loy) ? hiy - loy : '0;
  end

  always_ff @(posedge clk) begin
    touch1 <= touch_c;
    ov     <= OV_BITS'(sx) * OV_BITS'(sy);
    a1     <= AREA_BITS'(a.w) * AREA_BITS'(a.h);
    a2     <= AREA_BITS'(b.w) * AREA_BITS'(b.h);
    touch2 <= touch1;
    lhs    <= LHS_BITS'((OV_BITS + 4)'(ov) * (OV_BITS + 4)'(10)) *
              LHS_BITS'(AREA_BITS'(a1) + (AREA_BITS + 1)'(a2));
    rhs    <= RHS_BITS'((AREA_BITS + 4)'(a1) * (AREA_BITS + 4)'(13)) * RHS_BITS'(a2);
  end

  assign hit = touch2 && (lhs > LHS_BITS'(rhs));

endmodule

@@ rtl/oett_check.sv @@
// Port-level checker for the overlap event track table, bound to the top level.
module oett_check import oett_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [OUT_TDATA_BITS-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[5]))
    else $error("matched and table_full both set");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[4:1] == '0)
    else $error("dropped word carries a slot");

  a_closed_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:6] <= CNT_BITS'(DEPTH))
    else $error("closed count beyond table depth");

endmodule

bind overlap_event_track_table_top oett_check u_oett_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ bench/tb_overlap_event_track_table_top.sv @@
// Testbench for the overlap event track table: queued stimulus, clocked driver and monitor.
`timescale 1ns / 100ps

module tb_overlap_event_track_table_top;
  import oett_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE = 60;

  typedef struct {
    logic                  op;
    box_t                  box;
    logic [FRAME_BITS-1:0] frame;
  } det_word_t;

  typedef struct {
    logic                matched;
    logic [IDX_BITS-1:0] slot;
    logic                full;
    logic [CNT_BITS-1:0] closed;
  } track_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_BITS-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_FPS;
  logic [15:0] cfg_data = '0;

  overlap_event_track_table_top u_top (.*);

  always #10 clk = ~clk;

  // tracker shadow
  box_t                  trk_box   [DEPTH];
  logic [FRAME_BITS-1:0] trk_start [DEPTH];
  logic [FRAME_BITS-1:0] trk_end   [DEPTH];
  logic                  trk_open  [DEPTH];
  logic                  trk_seen  [DEPTH];
  int                    trk_cnt = 0;
  logic [7:0]            trk_fps = FPS_RESET;
  logic [15:0]           trk_min_start = MIN_START_RESET;

  det_word_t  pending[$];
  track_res_t expected_res[$];
  det_word_t  cur;
  int n_pushed = 0, n_taken = 0, errors = 0, cycles = 0, gap_left = 0, stall_left = 0;
  logic took = 1'b0;
  bit no_idle = 0;

  function automatic longint unsigned shared_len(longint unsigned a0, a1, b0, b1);
    longint unsigned lo, hi;
    lo = a0 > b0 ? a0 : b0;
    hi = a1 < b1 ? a1 : b1;
    return hi >= lo ? hi - lo : 0;
  endfunction

  function automatic bit boxes_overlap(box_t p, box_t q);
    longint unsigned x1, y1, w1, h1, x2, y2, w2, h2, ov, a1, a2;
    x1 = p.x; y1 = p.y; w1 = p.w; h1 = p.h;
    x2 = q.x; y2 = q.y; w2 = q.w; h2 = q.h;
    if (x1 + w1 < x2 || x1 > x2 + w2 || y1 + h1 < y2 || y1 > y2 + h2) return 0;
    ov = shared_len(x1, x1 + w1, x2, x2 + w2) * shared_len(y1, y1 + h1, y2, y2 + h2);
    a1 = w1 * h1;
    a2 = w2 * h2;
    return 10 * ov * (a1 + a2) > 13 * a1 * a2;
  endfunction

  function automatic track_res_t track_step(det_word_t d);
    track_res_t r;
    int i, closed;
    longint dur;
    r = '{1'b0, '0, 1'b0, '0};
    if (d.op == 1'b0) begin
      for (i = 0; i < trk_cnt; i++) begin
        if (trk_open[i] && boxes_overlap(trk_box[i], d.box)) begin
          trk_seen[i] = 1'b1;
          trk_box[i] = d.box;
          r.matched = 1'b1;
          r.slot = i[IDX_BITS-1:0];
          return r;
        end
      end
      if (trk_cnt >= DEPTH) begin
        r.full = 1'b1;
        return r;
      end
      trk_box[trk_cnt] = d.box;
      trk_start[trk_cnt] = d.frame;
      trk_end[trk_cnt] = '0;
      trk_open[trk_cnt] = 1'b1;
      trk_seen[trk_cnt] = 1'b1;
      r.slot = trk_cnt[IDX_BITS-1:0];
      trk_cnt++;
      return r;
    end
    closed = 0;
    i = 0;
    while (i < trk_cnt) begin
      if (trk_seen[i]) begin
        trk_seen[i] = 1'b0;
        i++;
        continue;
      end
      closed++;
      if (trk_open[i]) begin
        trk_end[i] = d.frame;
        trk_open[i] = 1'b0;
        dur = longint'(trk_end[i]) - longint'(trk_start[i]);
        if (dur < 2 * longint'(trk_fps) || trk_start[i] < trk_min_start) begin
          for (int k = i; k < trk_cnt - 1; k++) begin
            trk_box[k] = trk_box[k+1];
            trk_start[k] = trk_start[k+1];
            trk_end[k] = trk_end[k+1];
            trk_open[k] = trk_open[k+1];
            trk_seen[k] = trk_seen[k+1];
          end
          trk_cnt--;
          closed--;
          continue;
        end
      end
      i++;
    end
    r.closed = closed[CNT_BITS-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!s_tvalid || took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        cur = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= cur.op;
        s_tdata <= {cur.frame, cur.box.h, cur.box.w, cur.box.y, cur.box.x};
        gap_left <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    took <= s_tvalid && s_tready;
    if (s_tvalid && s_tready) begin
      expected_res.insert(expected_res.size(), track_step(cur));
      n_taken++;
    end
  end

  // monitor
  always @(posedge clk) begin
    track_res_t w;
    if (m_tvalid && m_tready) begin
      if (expected_res.size() == 0) begin
        report("unexpected word", int'(m_tdata), 0);
      end else begin
        w = expected_res.pop_front();
        if (m_tdata[0] !== w.matched) report("matched", m_tdata[0], w.matched);
        if (m_tdata[4:1] !== w.slot) report("slot_index", m_tdata[4:1], w.slot);
        if (m_tdata[5] !== w.full) report("table_full", m_tdata[5], w.full);
        if (m_tdata[10:6] !== w.closed) report("closed_count", m_tdata[10:6], w.closed);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout");
      $display("tb_overlap_event_track_table_top: errors");
      $finish;
    end
  end

  task automatic push_word(logic op, box_t b, logic [FRAME_BITS-1:0] f);
    det_word_t d;
    d = '{op, b, f};
    pending.insert(pending.size(), d);
    n_pushed++;
  endtask

  function automatic box_t mk_box(int x, int y, int w, int h);
    box_t b;
    b.x = x[11:0]; b.y = y[11:0]; b.w = w[11:0]; b.h = h[11:0];
    return b;
  endfunction

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FPS) trk_fps = val[7:0];
    else trk_min_start = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (n_taken != n_pushed || expected_res.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic int clampc(int v);
    return v < 0 ? 0 : (v > 4095 ? 4095 : v);
  endfunction

  box_t objs[$];
  int frame_no = 100;

  task automatic run_scene(int n_items);
    int sent, spawn;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(1'($urandom_range(0, 1)), box_t'(48'({$urandom(), $urandom()})),
                  FRAME_BITS'($urandom()));
        sent++;
      end
      spawn = ($urandom_range(0, 19) == 0) ? 18 : $urandom_range(0, 2);
      if (objs.size() < 3) spawn++;
      repeat (spawn) begin
        if ($urandom_range(0, 19) == 0)
          objs.insert(objs.size(), mk_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                                          $urandom_range(0, 4095), $urandom_range(0, 4095)));
        else
          objs.insert(objs.size(), mk_box($urandom_range(0, 3800), $urandom_range(0, 3800),
                                          $urandom_range(4, 250), $urandom_range(4, 250)));
      end
      foreach (objs[k]) begin
        objs[k] = mk_box(clampc(int'(objs[k].x) + int'($urandom_range(0, 4)) - 2),
                         clampc(int'(objs[k].y) + int'($urandom_range(0, 4)) - 2),
                         objs[k].w, objs[k].h);
        if ($urandom_range(0, 9) < 8) begin
          push_word(1'b0, objs[k], FRAME_BITS'(frame_no));
          sent++;
        end
      end
      for (int k = objs.size() - 1; k >= 0; k--)
        if ($urandom_range(0, 9) == 0) objs.delete(k);
      if ($urandom_range(0, 29) == 0) push_word(1'b1, '0, FRAME_BITS'($urandom()));
      else push_word(1'b1, '0, FRAME_BITS'(frame_no));
      sent++;
      frame_no += ($urandom_range(0, 9) == 0) ? $urandom_range(2, 50) : 1;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings
    push_word(1'b0, mk_box(10, 10, 100, 100), 20);
    push_word(1'b0, mk_box(11, 10, 100, 100), 21);
    push_word(1'b0, mk_box(4095, 4095, 4095, 4095), 22);
    push_word(1'b0, mk_box(4095, 4095, 4095, 4095), 23);
    push_word(1'b0, mk_box(500, 500, 0, 0), 24);
    push_word(1'b0, mk_box(500, 500, 0, 0), 25);
    push_word(1'b0, mk_box(900, 900, 0, 40), 26);
    push_word(1'b0, mk_box(900, 900, 0, 40), 27);
    push_word(1'b0, mk_box(0, 0, 4095, 4095), 16777215);
    push_word(1'b1, '0, 30);
    push_word(1'b0, mk_box(12, 10, 100, 100), 31);
    push_word(1'b1, '0, 200);
    push_word(1'b1, '0, 16777215);
    push_word(1'b1, '0, 0);
    drain();

    write_reg(CFG_FPS, 16'd1);
    write_reg(CFG_MIN_START, 16'd0);
    no_idle = 1;
    run_scene(150);
    drain();
    no_idle = 0;

    write_reg(CFG_FPS, 16'd0);
    run_scene(150);
    drain();

    write_reg(CFG_FPS, 16'd255);
    write_reg(CFG_MIN_START, 16'd65535);
    run_scene(120);
    drain();

    write_reg(CFG_FPS, 16'd3);
    write_reg(CFG_MIN_START, 16'd150);
    run_scene(150);
    drain();

    write_reg(CFG_FPS, 16'hFF02);
    write_reg(CFG_MIN_START, 16'hAAAA);
    frame_no = 43000;
    run_scene(150);
    drain();

    write_reg(CFG_FPS, 16'd2);
    write_reg(CFG_MIN_START, 16'h5555);
    frame_no = 21800;
    run_scene(150);
    drain();

    if (errors == 0)
      $display("tb_overlap_event_track_table_top: clean");
    else
      $display("tb_overlap_event_track_table_top: errors");
    $finish;
  end

endmodule
